// ----- src/bbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared types and constants for the edge-normalized RGB box blur.
// ----------------------------------------------------------------------------
package bbe_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 4;
  localparam int MAX_HEIGHT     = 4096;
  localparam int PIX_W          = 8;
  localparam int NUM_CH         = 3;
  localparam int CFG_W          = 13;

  localparam logic [10:0] RST_IMG_WIDTH   = 11'd1024;
  localparam logic [12:0] RST_IMG_HEIGHT  = 13'd1024;
  localparam logic [2:0]  RST_BLUR_RADIUS = 3'd1;

  typedef enum logic [1:0] {
    CFG_IMG_WIDTH   = 2'd0,
    CFG_IMG_HEIGHT  = 2'd1,
    CFG_BLUR_RADIUS = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAPS,
    ST_FLUSH,
    ST_LAUNCH,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

// ----- src/bbe_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_div_cell
// One restoring-division cell: resolves one quotient bit on all channels.
// ----------------------------------------------------------------------------
module bbe_div_cell import bbe_pkg::*; #(
  parameter int SUM_W = 15,
  parameter int CNT_W = 7,
  parameter int SHIFT = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              i_vld,
  input  logic [CNT_W-1:0]                  i_div,
  input  logic [NUM_CH-1:0][SUM_W-1:0]      i_rem,
  input  logic [NUM_CH-1:0][PIX_W-1:0]      i_quo,
  output logic                              o_vld,
  output logic [CNT_W-1:0]                  o_div,
  output logic [NUM_CH-1:0][SUM_W-1:0]      o_rem,
  output logic [NUM_CH-1:0][PIX_W-1:0]      o_quo
);

  localparam int EW = SUM_W + PIX_W;

  logic                         vld_r;
  logic [CNT_W-1:0]             div_r;
  logic [NUM_CH-1:0][SUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_CH-1:0][PIX_W-1:0] quo_r, quo_nxt;
  logic [EW-1:0]                trial;

  always_comb begin
    trial = EW'(i_div) << SHIFT;
    for (int c = 0; c < NUM_CH; c++) begin
      if (EW'(i_rem[c]) >= trial) begin
        rem_nxt[c] = SUM_W'(EW'(i_rem[c]) - trial);
        quo_nxt[c] = {i_quo[c][PIX_W-2:0], 1'b1};
      end else begin
        rem_nxt[c] = i_rem[c];
        quo_nxt[c] = {i_quo[c][PIX_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= i_div;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign o_vld = vld_r;
  assign o_div = div_r;
  assign o_rem = rem_r;
  assign o_quo = quo_r;

endmodule

// ----- src/bbe_div_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_div_chain
// Row of division cells, MSB first; window sum over tap count, floored.
// ----------------------------------------------------------------------------
module bbe_div_chain import bbe_pkg::*; #(
  parameter int SUM_W = 15,
  parameter int CNT_W = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [CNT_W-1:0]             in_div,
  input  logic [NUM_CH-1:0][SUM_W-1:0] in_rem,
  output logic                         out_vld,
  output logic [NUM_CH-1:0][PIX_W-1:0] out_quo
);

  logic                         vld_w [PIX_W+1];
  logic [CNT_W-1:0]             div_w [PIX_W+1];
  logic [NUM_CH-1:0][SUM_W-1:0] rem_w [PIX_W+1];
  logic [NUM_CH-1:0][PIX_W-1:0] quo_w [PIX_W+1];

  assign vld_w[0] = in_vld;
  assign div_w[0] = in_div;
  assign rem_w[0] = in_rem;
  assign quo_w[0] = '0;

  for (genvar k = 0; k < PIX_W; k++) begin : g_cell
    bbe_div_cell #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W),
      .SHIFT (PIX_W - 1 - k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .i_vld (vld_w[k]),
      .i_div (div_w[k]),
      .i_rem (rem_w[k]),
      .i_quo (quo_w[k]),
      .o_vld (vld_w[k+1]),
      .o_div (div_w[k+1]),
      .o_rem (rem_w[k+1]),
      .o_quo (quo_w[k+1])
    );
  end

  assign out_vld = vld_w[PIX_W];
  assign out_quo = quo_w[PIX_W];

endmodule

// ----- src/rgb_box_blur_edge_normalized_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_blur_edge_normalized_unit
// Streaming RGB box blur, window cut off at the frame edges.
// ----------------------------------------------------------------------------
// Pixels of one frame come in raster order; the blurred frame leaves in raster
// order, each channel the floor mean over the (2r+1)x(2r+1) window counting
// only taps inside the frame. Output k leaves with input pixel k + r*W + r;
// drain words (opcode 1) after the last pixel push out the rest, and the last
// output carries frame_last. A word that releases no output does not stall
// the input side. One that releases an output holds it through the window
// walk, a step per window tap with a line-store read for each tap inside the
// frame, then the eight-cell divider row and the hand-over to the output
// register. The output register lets the next input word be taken while a
// result waits. The line store holds 2*r*W + 2*r + 1 pixels at the largest
// radius and width and needs no clear after reset. A write to a known index
// restarts the frame; after any write the input stalls while constants settle.
// ----------------------------------------------------------------------------
module rgb_box_blur_edge_normalized_unit import bbe_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input words
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic [PIX_W-1:0] in_red,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_blue,
  // result words
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_red,
  output logic [PIX_W-1:0] out_green,
  output logic [PIX_W-1:0] out_blue,
  output logic             out_frame_last,
  // configuration
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // ring size covers r rows on either side plus r pixels on either side of the center tap
  localparam int RING = 2*MAX_RADIUS*MAX_WIDTH + 2*MAX_RADIUS + 1;
  localparam int AW   = $clog2(RING);
  localparam int SW   = AW + 2;                       // signed pointer math
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int YRW  = $clog2(MAX_HEIGHT);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int TW   = $clog2(MAX_WIDTH*MAX_HEIGHT + 1);
  localparam int NTAP = (2*MAX_RADIUS + 1) * (2*MAX_RADIUS + 1);
  localparam int CNTW = $clog2(NTAP + 1);
  localparam int SUMW = $clog2(NTAP * ((1 << PIX_W) - 1) + 1);
  localparam int YW   = YRW + 2;
  localparam int XW   = WW + 1;

  // configuration registers and derived frame constants
  logic [10:0]          cfg_w_r;
  logic [12:0]          cfg_h_r;
  logic [2:0]           cfg_r_r;
  logic                 cfg_busy_r;
  logic                 cfg_hit;
  logic [WW-1:0]        eff_w, eff_w_r;
  logic [HW-1:0]        eff_h, eff_h_r;
  logic [RW-1:0]        eff_r, eff_r_r;
  logic [TW-1:0]        total_r, lag_r;
  logic signed [SW-1:0] step_r;

  // frame position
  logic [TW-1:0]        in_idx_r, out_idx_r, in_idx_inc;
  logic [AW-1:0]        wr_ptr_r, out_ptr_r;
  logic [CW-1:0]        out_col_r;
  logic [YRW-1:0]       out_row_r;

  // window walk
  state_t               state_r, state_nxt;
  logic signed [RW:0]   ta_r, tb_r, r_s;
  logic [AW-1:0]        tap_ptr_r, tap_ptr_nxt, start_ptr;
  logic signed [SW-1:0] sp, np, stp;
  logic signed [YW-1:0] tap_y;
  logic signed [XW-1:0] tap_x;
  logic                 tap_ok, last_tap;
  logic [CNTW-1:0]      cnt_r;
  logic [NUM_CH-1:0][SUMW-1:0] acc_r;

  // line store
  logic [NUM_CH-1:0][PIX_W-1:0] mem [RING];
  logic [NUM_CH-1:0][PIX_W-1:0] rd_data_r;
  logic                         rd_vld_r;

  // divider and result
  logic                         div_vld;
  logic [NUM_CH-1:0][PIX_W-1:0] div_quo, res_r;
  logic [NUM_CH-1:0][PIX_W-1:0] out_pix_r;
  logic                         out_valid_r, out_last_r;

  // handshake and control
  logic in_acc, in_full, wr_en, due, rd_en, launch, emit, frame_end;
  logic [TW:0] due_lim;

  // ---------------- configuration ----------------
  always_comb begin
    unique case (cfg_idx_t'(cfg_index))
      CFG_IMG_WIDTH, CFG_IMG_HEIGHT, CFG_BLUR_RADIUS: cfg_hit = cfg_we;
      default:                                        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r    <= RST_IMG_WIDTH;
      cfg_h_r    <= RST_IMG_HEIGHT;
      cfg_r_r    <= RST_BLUR_RADIUS;
      cfg_busy_r <= 1'b0;
    end else begin
      cfg_busy_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_IMG_WIDTH:   cfg_w_r <= cfg_wdata[10:0];
          CFG_IMG_HEIGHT:  cfg_h_r <= cfg_wdata[12:0];
          CFG_BLUR_RADIUS: cfg_r_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
  end

  // out-of-range settings clamp to the nearest legal value
  always_comb begin
    if (cfg_w_r == '0)                  eff_w = WW'(1);
    else if (32'(cfg_w_r) > MAX_WIDTH)  eff_w = WW'(MAX_WIDTH);
    else                                eff_w = WW'(cfg_w_r);
    if (cfg_h_r == '0)                  eff_h = HW'(1);
    else if (32'(cfg_h_r) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else                                eff_h = HW'(cfg_h_r);
    if (32'(cfg_r_r) > MAX_RADIUS)      eff_r = RW'(MAX_RADIUS);
    else                                eff_r = RW'(cfg_r_r);
  end

  always_ff @(posedge clk) begin
    eff_w_r <= eff_w;
    eff_h_r <= eff_h;
    eff_r_r <= eff_r;
    total_r <= TW'(eff_w) * TW'(eff_h);
    lag_r   <= TW'(eff_r) * TW'(eff_w) + TW'(eff_r);
    step_r  <= $signed(SW'(eff_w)) - $signed(SW'({eff_r, 1'b0}));
  end

  // ---------------- input side ----------------
  assign in_acc     = in_valid & in_ready;
  assign in_full    = (in_idx_r == total_r);
  assign wr_en      = in_acc && (opcode_t'(in_opcode) == OP_PIXEL) && !in_full;
  assign in_idx_inc = in_idx_r + TW'(wr_en);
  assign due_lim    = {1'b0, out_idx_r} + {1'b0, lag_r};
  // drain before frame end gives nothing; otherwise release once the window
  // below-right of the next output is in, or the frame is complete
  assign due = in_acc && (wr_en || in_full) &&
               ((in_idx_inc == total_r) || ({1'b0, in_idx_inc} > due_lim));
  assign frame_end = (out_idx_r + TW'(1) == total_r);

  // ---------------- window walk ----------------
  assign r_s      = $signed({1'b0, eff_r_r});
  assign tap_y    = $signed(YW'(out_row_r)) + YW'(ta_r);
  assign tap_x    = $signed(XW'(out_col_r)) + XW'(tb_r);
  assign tap_ok   = (tap_y >= 0) && (tap_y < $signed(YW'(eff_h_r))) &&
                    (tap_x >= 0) && (tap_x < $signed(XW'(eff_w_r)));
  assign last_tap = (ta_r == r_s) && (tb_r == r_s);

  // first tap sits lag pixels behind the output position in the ring
  always_comb begin
    sp = $signed(SW'(out_ptr_r)) - $signed(SW'(lag_r));
    if (sp < 0) sp = sp + SW'(RING);
    start_ptr = AW'(sp);
  end

  // next tap: one pixel right, or down a row back to the left edge
  always_comb begin
    stp = (tb_r == r_s) ? step_r : SW'(1);
    np  = $signed(SW'(tap_ptr_r)) + stp;
    if (np < 0)                 np = np + SW'(RING);
    else if (np >= SW'(RING))   np = np - SW'(RING);
    tap_ptr_nxt = AW'(np);
  end

  // ---------------- state machine ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (due) state_nxt = ST_TAPS;
      ST_TAPS:   if (last_tap) state_nxt = ST_FLUSH;
      ST_FLUSH:  state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_DIV;
      ST_DIV:    if (div_vld) state_nxt = ST_HOLD;
      ST_HOLD:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE) && !cfg_busy_r;
    rd_en    = (state_r == ST_TAPS) && tap_ok;
    launch   = (state_r == ST_LAUNCH);
    emit     = (state_r == ST_HOLD) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
    end
  end

  // ---------------- frame counters ----------------
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      in_idx_r  <= '0;
      out_idx_r <= '0;
      wr_ptr_r  <= '0;
      out_ptr_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      if (wr_en) begin
        in_idx_r <= in_idx_inc;
        wr_ptr_r <= (32'(wr_ptr_r) == RING - 1) ? '0 : wr_ptr_r + AW'(1);
      end
      if (emit) begin
        if (frame_end) begin
          in_idx_r  <= '0;
          out_idx_r <= '0;
          wr_ptr_r  <= '0;
          out_ptr_r <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end else begin
          out_idx_r <= out_idx_r + TW'(1);
          out_ptr_r <= (32'(out_ptr_r) == RING - 1) ? '0 : out_ptr_r + AW'(1);
          if (WW'(out_col_r) + WW'(1) >= eff_w_r) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + YRW'(1);
          end else begin
            out_col_r <= out_col_r + CW'(1);
          end
        end
      end
    end
  end

  // ---------------- tap walk and accumulation ----------------
  always_ff @(posedge clk) begin
    if (due) begin
      ta_r      <= -r_s;
      tb_r      <= -r_s;
      tap_ptr_r <= start_ptr;
      cnt_r     <= '0;
    end else if (state_r == ST_TAPS) begin
      if (tb_r == r_s) begin
        tb_r <= -r_s;
        ta_r <= ta_r + (RW+1)'(1);
      end else begin
        tb_r <= tb_r + (RW+1)'(1);
      end
      tap_ptr_r <= tap_ptr_nxt;
      cnt_r     <= cnt_r + CNTW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (due) begin
      acc_r <= '0;
    end else if (rd_vld_r) begin
      for (int c = 0; c < NUM_CH; c++) begin
        acc_r[c] <= acc_r[c] + SUMW'(rd_data_r[c]);
      end
    end
  end

  // ---------------- line store ----------------
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= {in_red, in_green, in_blue};
    if (rd_en) rd_data_r <= mem[tap_ptr_r];
  end

  // ---------------- divider row ----------------
  bbe_div_chain #(
    .SUM_W (SUMW),
    .CNT_W (CNTW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (launch),
    .in_div  (cnt_r),
    .in_rem  (acc_r),
    .out_vld (div_vld),
    .out_quo (div_quo)
  );

  always_ff @(posedge clk) begin
    if (div_vld) res_r <= div_quo;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pix_r  <= res_r;
      out_last_r <= frame_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_pix_r[2];
  assign out_green      = out_pix_r[1];
  assign out_blue       = out_pix_r[0];
  assign out_frame_last = out_last_r;

  // ---------------- assertions ----------------
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld |-> (state_r == ST_DIV))
    else $error("divider result outside divide wait");

  a_taps_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LAUNCH) |-> (cnt_r != '0))
    else $error("window launched with no taps");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("result word lost at output register");

  a_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (in_idx_r <= total_r))
    else $error("input count past frame size");

endmodule

// ----- sim/bbe_blur_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_blur_checker
// Watches the pixel, blurred-pixel and register ports of the box blur, keeps
// its own copy of the line store and frame counters, works out each blurred
// word when an input word is taken, and compares the words that leave.
// ----------------------------------------------------------------------------
module bbe_blur_checker import bbe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_opcode,
  input  logic [PIX_W-1:0] in_red,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_blue,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [PIX_W-1:0] out_red,
  input  logic [PIX_W-1:0] out_green,
  input  logic [PIX_W-1:0] out_blue,
  input  logic             out_frame_last,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               blur_pending
);

  localparam int RING = 2 * MAX_RADIUS_DEF * MAX_WIDTH_DEF + 2 * MAX_RADIUS_DEF + 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_word_t;

  blur_word_t  blurred_q[$];
  logic [23:0] line_ring [RING];
  logic [10:0] reg_width;
  logic [12:0] reg_height;
  logic [2:0]  reg_radius;
  int unsigned pix_col, pix_row, blur_col, blur_row;

  function automatic void restart_frame();
    pix_col = 0; pix_row = 0; blur_col = 0; blur_row = 0;
  endfunction

  function automatic void blur_step(logic op, logic [7:0] rd, logic [7:0] gr,
                                    logic [7:0] bl);
    int unsigned w, h, rad, total, lag, pix_idx, blur_idx, sr, sg, sb, taps;
    int y, x;
    blur_word_t res;
    w   = (reg_width == 0) ? 1 : (reg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : reg_width;
    h   = (reg_height == 0) ? 1 : (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height;
    rad = (reg_radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : reg_radius;
    total    = w * h;
    lag      = rad * w + rad;
    pix_idx  = pix_row * w + pix_col;
    blur_idx = blur_row * w + blur_col;
    sr = 0; sg = 0; sb = 0; taps = 0;
    if (op == OP_PIXEL && pix_idx < total) begin
      line_ring[pix_idx % RING] = {rd, gr, bl};
      pix_idx++;
      pix_col++;
      if (pix_col >= w) begin
        pix_col = 0;
        pix_row++;
      end
    end else if (pix_idx < total) begin
      return;  // drain ahead of frame end does nothing
    end
    if (blur_idx >= total) return;
    if (!(pix_idx == total || pix_idx > blur_idx + lag)) return;
    for (int a = -int'(rad); a <= int'(rad); a++) begin
      y = int'(blur_row) + a;
      if (y < 0 || y >= int'(h)) continue;
      for (int b = -int'(rad); b <= int'(rad); b++) begin
        x = int'(blur_col) + b;
        if (x < 0 || x >= int'(w)) continue;
        sr += line_ring[(y * w + x) % RING][23:16];
        sg += line_ring[(y * w + x) % RING][15:8];
        sb += line_ring[(y * w + x) % RING][7:0];
        taps++;
      end
    end
    if (taps == 0) taps = 1;
    res.red   = 8'(sr / taps);
    res.green = 8'(sg / taps);
    res.blue  = 8'(sb / taps);
    res.last  = (blur_idx + 1 == total);
    blurred_q.push_back(res);
    if (res.last) begin
      restart_frame();
    end else begin
      blur_col++;
      if (blur_col >= w) begin
        blur_col = 0;
        blur_row++;
      end
    end
  endfunction

  always @(posedge clk) begin
    blur_word_t exp_w;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      reg_width  = RST_IMG_WIDTH;
      reg_height = RST_IMG_HEIGHT;
      reg_radius = RST_BLUR_RADIUS;
      restart_frame();
      blurred_q.delete();
      fail_count   <= 0;
      blur_pending <= 0;
    end else begin
      // only a known register index restarts the frame
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMG_WIDTH: begin
            reg_width = cfg_wdata[10:0];
            restart_frame();
          end
          CFG_IMG_HEIGHT: begin
            reg_height = cfg_wdata[12:0];
            restart_frame();
          end
          CFG_BLUR_RADIUS: begin
            reg_radius = cfg_wdata[2:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (blurred_q.size() == 0) begin
          $error("blurred word with none expected");
          errs++;
        end else begin
          exp_w = blurred_q.pop_front();
          if (out_red !== exp_w.red) begin
            $error("out_red: expected %0d, got %0d", exp_w.red, out_red);
            errs++;
          end
          if (out_green !== exp_w.green) begin
            $error("out_green: expected %0d, got %0d", exp_w.green, out_green);
            errs++;
          end
          if (out_blue !== exp_w.blue) begin
            $error("out_blue: expected %0d, got %0d", exp_w.blue, out_blue);
            errs++;
          end
          if (out_frame_last !== exp_w.last) begin
            $error("out_frame_last: expected %0d, got %0d", exp_w.last, out_frame_last);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) blur_step(in_opcode, in_red, in_green, in_blue);
      fail_count   <= fail_count + errs;
      blur_pending <= blurred_q.size();
    end
  end

endmodule

// ----- sim/rgb_box_blur_edge_normalized_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_blur_edge_normalized_unit_tb
// Frame-level regression of the edge-normalized RGB box blur: whole frames of
// many sizes and radii, register clamping, stray drains and late pixels, under
// several idle and stall mixes, all checked word by word by bbe_blur_checker.
// ----------------------------------------------------------------------------
module rgb_box_blur_edge_normalized_unit_tb;
  import bbe_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid, in_ready, in_opcode;
  logic [PIX_W-1:0] in_red, in_green, in_blue;
  logic             out_valid, out_ready;
  logic [PIX_W-1:0] out_red, out_green, out_blue;
  logic             out_frame_last;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int               fail_count, blur_pending;

  // idle mix in percent, changed between frames
  int send_idle_pct, stall_pct;
  int words_sent;
  bit hold_go;     // asks the receiver for one long hold-off
  int hold_left;

  rgb_box_blur_edge_normalized_unit dut (.*);

  bbe_blur_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // safety net: far beyond the slowest legal run
  initial begin
    #50ms;
    $display("rgb_box_blur_edge_normalized_unit regression: fail");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off counted here on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one word on the input channel; entered and left at a falling edge.
  // in_ready is steady from a falling edge to the next rising edge.
  task automatic push_word(logic op, logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_red    <= rd;
    in_green  <= gr;
    in_blue   <= bl;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // registers change only once the block has gone quiet
  task automatic write_regs(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                            logic [CFG_W-1:0] r);
    in_valid <= 1'b0;
    while (blur_pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);  // a drain may still be computing nothing
    cfg_we <= 1'b1; cfg_index <= CFG_IMG_WIDTH;   cfg_wdata <= w; @(negedge clk);
    cfg_index <= CFG_IMG_HEIGHT;  cfg_wdata <= h; @(negedge clk);
    cfg_index <= CFG_BLUR_RADIUS; cfg_wdata <= r; @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] chan_val(int mode);
    case (mode)
      0: return 8'd0;
      1: return 8'd255;
      default: return ($urandom_range(9) == 0) ? 8'(255 * $urandom_range(1)) :
                                                 8'($urandom_range(255));
    endcase
  endfunction

  // a whole frame: pixels, then enough drain ticks to flush it.
  // noise adds stray drains mid-frame, late pixels and extra drains.
  task automatic blur_frame(int w, int h, int r, int mode, bit noise, bit pause_mid);
    int total, lag, flush;
    total = w * h;
    lag   = r * w + r;
    flush = (lag >= total) ? total - 1 : lag;
    for (int i = 0; i < total; i++) begin
      if (noise && $urandom_range(15) == 0)
        push_word(OP_DRAIN, chan_val(2), chan_val(2), chan_val(2));
      if (pause_mid && i == total / 2) begin
        in_valid <= 1'b0;
        while (blur_pending != 0) @(negedge clk);
        @(negedge clk);
      end
      push_word(OP_PIXEL, chan_val(mode), chan_val(mode), chan_val(mode));
    end
    for (int i = 0; i < flush; i++) begin
      if (noise && $urandom_range(3) == 0)
        push_word(OP_PIXEL, chan_val(2), chan_val(2), chan_val(2));  // acts as drain
      else
        push_word(OP_DRAIN, chan_val(2), chan_val(2), chan_val(2));
    end
    if (noise) repeat ($urandom_range(2)) push_word(OP_DRAIN, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic set_mix(int k);
    case (k % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 76; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 76; end
      default: begin send_idle_pct = 21; stall_pct = 21; end
    endcase
  endtask

  initial begin
    int w, h, r, k;
    rst_n = 1'b0;
    in_valid = 1'b0; in_opcode = OP_PIXEL;
    in_red = '0; in_green = '0; in_blue = '0;
    cfg_we = 1'b0; cfg_index = CFG_IMG_WIDTH; cfg_wdata = '0;
    out_ready = 1'b0;
    hold_go = 1'b0; hold_left = 0;
    send_idle_pct = 0; stall_pct = 0; words_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: drain ahead of any pixel, all-black and all-white frames
    write_regs(3, 2, 1);
    push_word(OP_DRAIN, 8'd255, 8'd255, 8'd255);
    blur_frame(3, 2, 1, 0, 1'b0, 1'b0);
    blur_frame(3, 2, 1, 1, 1'b0, 1'b0);
    // zero width and height clamp to one pixel, radius 7 clamps to 4
    write_regs(0, 0, 7);
    blur_frame(1, 1, 4, 2, 1'b1, 1'b0);
    // lag longer than the frame; radius 0 passes pixels through
    write_regs(4, 3, 4);
    blur_frame(4, 3, 4, 1, 1'b1, 1'b0);
    write_regs(2, 2, 0);
    blur_frame(2, 2, 0, 2, 1'b1, 1'b0);

    // widest row, clamped from above
    write_regs(13'h7FF, 1, 0);
    blur_frame(MAX_WIDTH_DEF, 1, 0, 2, 1'b0, 1'b0);

    // random frames of small sizes under rotating idle mixes
    k = 0;
    while (words_sent < 1600 || k < 12) begin
      set_mix(k / 3);
      w = $urandom_range(12, 1);
      h = $urandom_range(8, 1);
      r = $urandom_range(4);
      write_regs(CFG_W'(w), CFG_W'(h), CFG_W'(r));
      if (k == 5) begin
        // long receiver hold-off while pixels keep coming
        write_regs(10, 8, 0);
        w = 10; h = 8; r = 0;
        send_idle_pct = 0;
        hold_go = 1'b1;
      end
      blur_frame(w, h, r, 2, $urandom_range(3) == 0, k == 9);
      k++;
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    fork
      while (blur_pending != 0) @(negedge clk);
      begin
        repeat (200000) @(negedge clk);
      end
    join_any
    disable fork;
    repeat (120) @(negedge clk);
    if (fail_count == 0 && blur_pending == 0) begin
      $display("rgb_box_blur_edge_normalized_unit regression: pass");
    end else begin
      $display("rgb_box_blur_edge_normalized_unit regression: fail");
    end
    $finish;
  end

endmodule
